// ===== design/rtt_pkg.sv =====
// Shared types and constants for the region thread/turbo tuner.
// Used by the interfaces, controller, datapath and top level.
package rtt_pkg;

  localparam int MAX_REGIONS = 64;
  localparam int SLOT_W      = $clog2(MAX_REGIONS);
  localparam int USED_W      = SLOT_W + 1;
  localparam int THREAD_W    = 9;
  localparam int ADDR_W      = 4;

  localparam logic [THREAD_W-1:0] THREAD_MAX = '1;

  // search phases
  localparam logic [2:0] PH_REPEAT      = 3'd0;
  localparam logic [2:0] PH_S0          = 3'd1;
  localparam logic [2:0] PH_S1          = 3'd2;
  localparam logic [2:0] PH_S2          = 3'd3;
  localparam logic [2:0] PH_END_THREADS = 3'd4;
  localparam logic [2:0] PH_END         = 3'd5;

  // gap phases
  localparam logic [1:0] GP_PASS      = 2'd0;
  localparam logic [1:0] GP_INITIAL   = 2'd1;
  localparam logic [1:0] GP_END_TURBO = 2'd2;
  localparam logic [1:0] GP_SETTLED   = 2'd3;

  // register indexes
  localparam logic [1:0] REG_METRIC    = 2'd0;
  localparam logic [1:0] REG_CORES     = 2'd1;
  localparam logic [1:0] REG_FIRST     = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  typedef struct packed {
    logic        metric_mode;
    logic [8:0]  core_count;
    logic [8:0]  first_threads;
    logic [31:0] switch_threshold;
  } cfg_t;

  // one region record; all-zero is the reset record
  typedef struct packed {
    logic [2:0]          search_phase;
    logic [1:0]          gap_phase;
    logic [1:0]          score_mode;
    logic [THREAD_W-1:0] trial_threads;
    logic [THREAD_W-1:0] prior_threads;
    logic [THREAD_W-1:0] step_size;
    logic [THREAD_W-1:0] best_threads;
    logic [63:0]         best_score;
    logic [31:0]         best_time;
    logic [1:0]          turbo_choice;
    logic [31:0]         par_off_time;
    logic [31:0]         par_on_time;
    logic [31:0]         gap_off_time;
    logic [31:0]         gap_on_time;
    logic [63:0]         gap_off_score;
    logic [63:0]         gap_on_score;
  } rec_t;

  typedef struct packed {
    logic load_in;
    logic rec_rd;
    logic rd_slot;
    logic upd_prev;
    logic key_rd;
    logic key_next;
    logic take_idx;
    logic alloc;
    logic set_cur;
    logic upd_slot;
  } cmd_t;

  typedef struct packed {
    logic op_end;
    logic used_empty;
    logic key_match;
    logic scan_last;
  } status_t;

endpackage

// ===== design/rtt_if.sv =====
// Valid/ready channel interfaces for tuner events and results.
// Depends on rtt_pkg for widths.
interface rtt_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] region_key;
  logic [31:0] elapsed_time;
  logic signed [31:0] energy_used;

  modport source (output valid, operation, region_key, elapsed_time, energy_used,
                  input ready);
  modport sink (input valid, operation, region_key, elapsed_time, energy_used,
                output ready);
endinterface

interface rtt_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] thread_count;
  logic       turbo_write;
  logic       turbo_value;
  logic [rtt_pkg::SLOT_W-1:0] region_index;
  logic       table_full;

  modport source (output valid, thread_count, turbo_write, turbo_value, region_index,
                  table_full, input ready);
  modport sink (input valid, thread_count, turbo_write, turbo_value, region_index,
                table_full, output ready);
endinterface

// ===== design/rtt_ctrl.sv =====
// Sequencing state machine for the tuner: record reads, key scan, result.
// Depends on rtt_pkg (cmd_t, status_t).
module rtt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rtt_pkg::status_t  status,
  output rtt_pkg::cmd_t     cmd
);
  import rtt_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RDP  = 3'd1;
  localparam logic [2:0] ST_UPDP = 3'd2;
  localparam logic [2:0] ST_KRD  = 3'd3;
  localparam logic [2:0] ST_KCMP = 3'd4;
  localparam logic [2:0] ST_RDS  = 3'd5;
  localparam logic [2:0] ST_UPDS = 3'd6;

  logic [2:0] state, state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_RDP;
        end
      end
      ST_RDP: begin
        cmd.rec_rd = 1'b1;
        state_next = ST_UPDP;
      end
      ST_UPDP: begin
        cmd.upd_prev = 1'b1;
        if (status.op_end) begin
          cmd.set_cur = 1'b1;
          state_next  = ST_RDS;
        end else if (status.used_empty) begin
          cmd.alloc  = 1'b1;
          state_next = ST_RDS;
        end else begin
          state_next = ST_KRD;
        end
      end
      ST_KRD: begin
        cmd.key_rd = 1'b1;
        state_next = ST_KCMP;
      end
      ST_KCMP: begin
        if (status.key_match) begin
          cmd.take_idx = 1'b1;
          state_next   = ST_RDS;
        end else if (status.scan_last) begin
          cmd.alloc  = 1'b1;
          state_next = ST_RDS;
        end else begin
          cmd.key_next = 1'b1;
          state_next   = ST_KRD;
        end
      end
      ST_RDS: begin
        cmd.rec_rd  = 1'b1;
        cmd.rd_slot = 1'b1;
        state_next  = ST_UPDS;
      end
      ST_UPDS: begin
        if (out_free) begin
          cmd.upd_slot = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.upd_slot) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_RDP))
    else $error("accepted transaction did not start a record read");

  a_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KCMP) |-> ($past(state) == ST_KRD))
    else $error("key compare without a key read");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDS && out_valid && !out_ready) |=> (state == ST_UPDS && out_valid))
    else $error("result overwritten while the receiver stalls");

endmodule

// ===== design/rtt_dp.sv =====
// Datapath: key table, region record memory, scoring and search update.
// Depends on rtt_pkg (rec_t, cmd_t, status_t, cfg_t, phase codes).
module rtt_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  rtt_pkg::cmd_t               cmd,
  output rtt_pkg::status_t            status,
  input  rtt_pkg::cfg_t               cfg,
  input  logic                        operation,
  input  logic [63:0]                 region_key,
  input  logic [31:0]                 elapsed_time,
  input  logic signed [31:0]          energy_used,
  output logic [8:0]                  thread_count,
  output logic                        turbo_write,
  output logic                        turbo_value,
  output logic [rtt_pkg::SLOT_W-1:0]  region_index,
  output logic                        table_full
);
  import rtt_pkg::*;

  logic [63:0] key_mem [MAX_REGIONS];
  rec_t        rec_mem [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] rec_vld;

  logic              op_q;
  logic [63:0]       key_q;
  logic [31:0]       time_q;
  logic signed [31:0] energy_q;
  logic [63:0]       prod_q;
  logic [USED_W-1:0] used_regions;
  logic [SLOT_W-1:0] current_slot, previous_slot, slot_q, key_idx;
  logic              full_q, gseq_q, pseq_q;
  logic [63:0]       key_rd_q;
  rec_t              rec_q;
  logic              rec_vld_q;
  rec_t              rec_cur, p_new, s_new;
  logic              prod_pos;
  logic [SLOT_W-1:0] rd_addr, wr_addr;
  logic              rec_we, key_we;
  logic [THREAD_W-1:0] thr_out;
  logic              wr_out, val_out;
  logic [64:0]       prod_full;

  assign prod_full = $signed({1'b0, time_q}) * energy_q;
  assign prod_pos  = !prod_q[63] && (prod_q != '0);
  assign rec_cur   = rec_vld_q ? rec_q : '0;

  assign status.op_end     = op_q;
  assign status.used_empty = (used_regions == '0);
  assign status.key_match  = (key_rd_q == key_q);
  assign status.scan_last  = ({1'b0, key_idx} + USED_W'(1)) == used_regions;

  function automatic logic [THREAD_W-1:0] sat_add(logic [THREAD_W-1:0] a,
                                                   logic [THREAD_W-1:0] b);
    logic [THREAD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[THREAD_W] ? THREAD_MAX : s[THREAD_W-1:0];
  endfunction

  // gap booking on a start, for the previous region's record
  always_comb begin
    logic        edp;
    logic [63:0] sc;
    p_new = rec_cur;
    edp   = cfg.metric_mode && !rec_cur.score_mode[1];
    sc    = edp ? prod_q : {32'b0, time_q};
    if (rec_cur.gap_phase == GP_INITIAL || rec_cur.gap_phase == GP_END_TURBO) begin
      if (edp && !prod_pos) begin
        p_new.gap_phase       = GP_PASS;
        p_new.score_mode[1]   = 1'b1;
        p_new.turbo_choice[1] = 1'b1;
      end else if (rec_cur.gap_phase == GP_INITIAL) begin
        p_new.gap_off_time    = time_q;
        p_new.gap_off_score   = sc;
        p_new.turbo_choice[1] = 1'b1;
        p_new.gap_phase       = GP_END_TURBO;
      end else begin
        p_new.gap_on_time  = time_q;
        p_new.gap_on_score = sc;
        p_new.gap_phase    = GP_SETTLED;
        if (rec_cur.gap_off_score < sc) p_new.turbo_choice[1] = 1'b0;
      end
    end
  end

  // slot record: search step on an end, result fields for both operations
  always_comb begin
    logic        edp, take, fin, par, gseq, sdown, sadd;
    logic [63:0] sc;
    logic [2:0]  ph;
    logic [THREAD_W:0] dbl;
    logic [THREAD_W-1:0] half;
    logic [32:0] sum_a, sum_b;
    s_new   = rec_cur;
    thr_out = '0;
    wr_out  = 1'b0;
    take    = 1'b0;
    fin     = 1'b0;
    sdown   = 1'b0;
    sadd    = 1'b0;
    edp     = cfg.metric_mode && !rec_cur.score_mode[0];
    sc      = edp ? prod_q : {32'b0, time_q};
    ph      = rec_cur.search_phase;
    dbl     = {rec_cur.trial_threads, 1'b0};
    half    = rec_cur.prior_threads >> 1;
    if (op_q) begin
      if (ph != PH_END) begin
        if (edp && !prod_pos) begin
          ph                   = PH_REPEAT;
          s_new.score_mode[0]  = 1'b1;
        end
        case (ph)
          PH_REPEAT: begin
            s_new.search_phase  = PH_S0;
            s_new.trial_threads = cfg.first_threads;
            s_new.prior_threads = cfg.first_threads;
          end
          PH_S0: begin
            take                = 1'b1;
            s_new.trial_threads = dbl[THREAD_W] ? THREAD_MAX : dbl[THREAD_W-1:0];
            s_new.search_phase  = PH_S1;
          end
          PH_S1: begin
            if (sc < rec_cur.best_score) begin
              take = 1'b1;
              if (dbl <= {1'b0, cfg.core_count}) begin
                s_new.prior_threads = rec_cur.trial_threads;
                s_new.trial_threads = dbl[THREAD_W] ? THREAD_MAX : dbl[THREAD_W-1:0];
              end else begin
                sdown = 1'b1;
              end
            end else if (rec_cur.best_threads == (cfg.core_count >> 1)) begin
              fin = 1'b1;
            end else begin
              sdown = 1'b1;
              sadd  = 1'b1;
            end
          end
          PH_S2: begin
            if (!(rec_cur.best_score < sc)) take = 1'b1;
            s_new.step_size = rec_cur.step_size >> 1;
            if (s_new.step_size >= THREAD_W'(2))
              s_new.trial_threads = sat_add(rec_cur.trial_threads, s_new.step_size);
            else
              fin = 1'b1;
          end
          PH_END_THREADS: begin
            s_new.search_phase = PH_END;
            s_new.par_on_time  = time_q;
            if (rec_cur.best_score < sc) s_new.turbo_choice[0] = 1'b0;
          end
          default: ;
        endcase
        if (sdown) begin
          s_new.step_size = half;
          if (half >= THREAD_W'(2)) begin
            if (sadd)
              s_new.trial_threads = sat_add(rec_cur.trial_threads, half);
            else
              s_new.trial_threads = (rec_cur.trial_threads > half) ?
                                    rec_cur.trial_threads - half : '0;
            s_new.search_phase = PH_S2;
          end else begin
            fin = 1'b1;
          end
        end
        if (take) begin
          s_new.best_score   = sc;
          s_new.best_time    = time_q;
          s_new.best_threads = rec_cur.trial_threads;
        end
        if (fin) begin
          s_new.turbo_choice[0] = 1'b1;
          s_new.par_off_time    = time_q;
          s_new.search_phase    = PH_END_THREADS;
        end
      end
      par   = s_new.turbo_choice[0];
      gseq  = s_new.turbo_choice[1];
      sum_a = {1'b0, rec_cur.gap_on_time} + {1'b0, cfg.switch_threshold};
      sum_b = {1'b0, rec_cur.gap_off_time} + {1'b0, cfg.switch_threshold};
      case (rec_cur.gap_phase)
        GP_PASS: begin
          s_new.gap_phase = GP_INITIAL;
          wr_out          = par != gseq;
        end
        GP_END_TURBO: wr_out = (par != gseq) && (cfg.switch_threshold < rec_cur.gap_off_time);
        GP_SETTLED: wr_out = (!par && gseq && sum_a < {1'b0, rec_cur.gap_off_time}) ||
                             (pseq_q && !par && sum_b < {1'b0, rec_cur.gap_on_time});
        default: ;
      endcase
      val_out = wr_out && gseq;
    end else begin
      par   = rec_cur.turbo_choice[0];
      gseq  = gseq_q;
      sum_a = {1'b0, rec_cur.par_on_time} + {1'b0, cfg.switch_threshold};
      sum_b = {1'b0, rec_cur.par_off_time} + {1'b0, cfg.switch_threshold};
      if (ph == PH_END) begin
        wr_out  = (!gseq && par && sum_a < {1'b0, rec_cur.par_off_time}) ||
                  (gseq && !par && sum_b < {1'b0, rec_cur.par_on_time});
        thr_out = rec_cur.best_threads;
      end else begin
        wr_out = rec_cur.best_time > cfg.switch_threshold;
        if (ph == PH_END_THREADS)  thr_out = rec_cur.best_threads;
        else if (ph == PH_REPEAT)  thr_out = cfg.core_count;
        else                       thr_out = rec_cur.trial_threads;
      end
      val_out = wr_out && par;
    end
  end

  assign rd_addr = cmd.rd_slot ? slot_q : previous_slot;
  assign rec_we  = (cmd.upd_prev && !op_q) || (cmd.upd_slot && op_q);
  assign wr_addr = cmd.upd_slot ? slot_q : previous_slot;
  assign key_we  = cmd.alloc && !used_regions[USED_W-1];

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[wr_addr] <= cmd.upd_slot ? s_new : p_new;
    if (cmd.rec_rd) begin
      rec_q     <= rec_mem[rd_addr];
      rec_vld_q <= rec_vld[rd_addr];
    end
    if (key_we) key_mem[used_regions[SLOT_W-1:0]] <= key_q;
    if (cmd.key_rd) key_rd_q <= key_mem[key_idx];
  end

  always_ff @(posedge clk) begin
    prod_q <= prod_full[63:0];
    if (cmd.load_in) begin
      op_q     <= operation;
      key_q    <= region_key;
      time_q   <= elapsed_time;
      energy_q <= energy_used;
    end
    if (cmd.upd_prev) begin
      gseq_q <= p_new.turbo_choice[1];
      pseq_q <= rec_cur.turbo_choice[1];
    end
    if (cmd.upd_slot) begin
      thread_count <= thr_out;
      turbo_write  <= wr_out;
      turbo_value  <= val_out;
      region_index <= slot_q;
      table_full   <= full_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_vld       <= '0;
      used_regions  <= '0;
      current_slot  <= SLOT_W'(MAX_REGIONS - 1);
      previous_slot <= '0;
      slot_q        <= '0;
      key_idx       <= '0;
      full_q        <= 1'b0;
    end else begin
      if (rec_we) rec_vld[wr_addr] <= 1'b1;
      if (cmd.load_in) begin
        key_idx <= '0;
        full_q  <= 1'b0;
      end
      if (cmd.key_next) key_idx <= key_idx + SLOT_W'(1);
      if (cmd.take_idx) slot_q <= key_idx;
      if (cmd.set_cur)  slot_q <= current_slot;
      if (cmd.alloc) begin
        if (!used_regions[USED_W-1]) begin
          slot_q       <= used_regions[SLOT_W-1:0];
          used_regions <= used_regions + USED_W'(1);
        end else begin
          slot_q <= SLOT_W'(MAX_REGIONS - 1);
          full_q <= 1'b1;
        end
      end
      if (cmd.upd_slot) begin
        if (op_q) previous_slot <= slot_q;
        else      current_slot  <= slot_q;
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_regions <= USED_W'(MAX_REGIONS))
    else $error("region count beyond table size");

  a_alloc_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.alloc && !used_regions[USED_W-1]) |=> (used_regions == $past(used_regions) + 1'b1))
    else $error("allocation did not bump region count");

  a_full_shares_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.alloc && used_regions[USED_W-1]) |=> (full_q && slot_q == SLOT_W'(MAX_REGIONS - 1)))
    else $error("full table did not fall back to the last slot");

endmodule

// ===== design/region_thread_turbo_tuner.sv =====
// Top level of the region thread/turbo tuner: APB config, control, datapath.
// Depends on rtt_pkg, rtt_if, rtt_ctrl and rtt_dp.
//
// Usage: region events enter on in_ch (valid/ready). Operation 0 (start)
// books the gap measurement against the previous region, looks up or
// allocates region_key and returns thread_count plus a turbo request.
// Operation 1 (end) scores the measurement and steps the thread search and
// the gap turbo trial. Every event gives exactly one transaction on out_ch.
// Each event reads the previous region's record; a start then scans the
// stored keys serially, one key read and compare at a time, up to all 64
// keys with a full table; last, the slot record is read and the result is
// registered. One event is in flight at a time; the next is accepted as
// soon as the result is in the output register, even while that result
// waits. A stalled receiver holds the result and the block stops before
// writing the next one.
// Reset clears all region records through per-slot valid bits at once; no
// clearing pass is needed. Config registers are to be written over APB only
// while idle; the block itself does not enforce this.
module region_thread_turbo_tuner (
  input  logic                       clk,
  input  logic                       rst,
  rtt_in_if.sink                     in_ch,
  rtt_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rtt_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import rtt_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.metric_mode      <= 1'b0;
      cfg.core_count       <= 9'd8;
      cfg.first_threads    <= 9'd2;
      cfg.switch_threshold <= 32'd776;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_METRIC:    cfg.metric_mode      <= pwdata[0];
        REG_CORES:     cfg.core_count       <= pwdata[8:0];
        REG_FIRST:     cfg.first_threads    <= pwdata[8:0];
        REG_THRESHOLD: cfg.switch_threshold <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_METRIC:    prdata = {31'b0, cfg.metric_mode};
      REG_CORES:     prdata = {23'b0, cfg.core_count};
      REG_FIRST:     prdata = {23'b0, cfg.first_threads};
      REG_THRESHOLD: prdata = cfg.switch_threshold;
      default:       prdata = '0;
    endcase
  end

  rtt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rtt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg          (cfg),
    .operation    (in_ch.operation),
    .region_key   (in_ch.region_key),
    .elapsed_time (in_ch.elapsed_time),
    .energy_used  (in_ch.energy_used),
    .thread_count (out_ch.thread_count),
    .turbo_write  (out_ch.turbo_write),
    .turbo_value  (out_ch.turbo_value),
    .region_index (out_ch.region_index),
    .table_full   (out_ch.table_full)
  );

endmodule
